>>> hw/rtl/salcmc_pkg.sv
// Shared constants, payload types and control structs for the LRU cache tag block.
package salcmc_pkg;

	localparam int LINE_SIZE  = 64;
	localparam int NUM_SETS   = 8;
	localparam int ADDR_BITS  = 32;
	localparam int WAYS_DEF   = 4;

	localparam int ADDR_W     = 32;
	localparam int EFF_ADDR_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int OFF_W      = $clog2(LINE_SIZE);
	localparam int SET_W      = $clog2(NUM_SETS);
	localparam int TAG_W      = EFF_ADDR_W - OFF_W - SET_W;
	localparam int COUNT_W    = 32;
	localparam int WAY_OUT_W  = 2;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic [WAY_OUT_W-1:0] way_used;
		logic [COUNT_W-1:0]   miss_count;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic commit;
	} cmd_t;

endpackage

>>> hw/rtl/set_assoc_lru_cache_miss_counter.sv
// On acceptance a request beat's set row and fields are registered; its result beat is
// registered in the output register at the commit, delayed only while the previous result
// still waits untaken. A new request is taken only once the previous one has committed.
// A request may be accepted while the previous result still waits in the output register.
// Reset clears the valid bits, the miss counter and the controller at once; the tag and
// rank rows are not cleared, since a way is only trusted once its valid bit is set.
module set_assoc_lru_cache_miss_counter import salcmc_pkg::*; #(
	parameter int WAYS = WAYS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// The controller only sequences: it issues the row read when a request beat is
	// taken and the commit once the output register can take the result.
	cmd_t cmd;

	salcmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// The datapath holds the set rows, the valid bits, the saturating miss counter
	// and the registered result beat. A clear request drops every valid bit and the
	// counter in the same commit that produces its all-zero result.
	salcmc_dp #(
		.WAYS (WAYS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> hw/rtl/salcmc_ctrl.sv
// Controller state machine: accepts a request beat, sequences the lookup and the result beat.
module salcmc_ctrl import salcmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd.rd_en  = req_valid && (state_q == ST_IDLE);
		cmd.commit = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_ready);
	end

	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/salcmc_dp.sv
// Datapath: tag and rank row memories, valid bits, hit and victim selection, miss counter.
module salcmc_dp import salcmc_pkg::*; #(
	parameter int WAYS = WAYS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
	typedef logic [WAYS-1:0][WIDX-1:0]  rank_row_t;

	// One row per set, read at the request's set, written back at the end.
	tag_row_t  tag_mem  [NUM_SETS];
	rank_row_t rank_mem [NUM_SETS];

	tag_row_t  tag_rd_q;
	rank_row_t rank_rd_q;
	logic                 mode_q;
	logic [SET_W-1:0]     set_q;
	logic [TAG_W-1:0]     tag_q;
	logic [NUM_SETS-1:0][WAYS-1:0] valid_q;
	logic [COUNT_W-1:0]   miss_q;
	rsp_t                 rsp_q;

	logic [SET_W-1:0]  req_set;
	logic [TAG_W-1:0]  req_tag;
	logic [WAYS-1:0]   row_valid;
	logic              found;
	logic              have_free;
	logic              evict;
	logic [WIDX-1:0]   hit_way;
	logic [WIDX-1:0]   free_way;
	logic [WIDX-1:0]   old_way;
	logic [WIDX-1:0]   pick;
	logic [WIDX:0]     old_rank;
	logic [WIDX+1:0]   pick_ext;
	tag_row_t          new_tags;
	rank_row_t         new_ranks;
	logic [COUNT_W-1:0] miss_next;

	assign req_set   = req.address[OFF_W +: SET_W];
	assign req_tag   = req.address[OFF_W + SET_W +: TAG_W];
	assign row_valid = valid_q[set_q];

	// Lowest-numbered hit, lowest-numbered free way, and the oldest way.
	always_comb begin
		found     = 1'b0;
		have_free = 1'b0;
		hit_way   = '0;
		free_way  = '0;
		old_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_valid[w] && (tag_rd_q[w] == tag_q)) begin
				found   = 1'b1;
				hit_way = WIDX'(w);
			end
			if (!row_valid[w]) begin
				have_free = 1'b1;
				free_way  = WIDX'(w);
			end
			if (rank_rd_q[w] == WIDX'(WAYS - 1)) begin
				old_way = WIDX'(w);
			end
		end
	end

	always_comb begin
		evict = !found && !have_free;
		priority if (found) begin
			pick = hit_way;
		end else if (have_free) begin
			pick = free_way;
		end else begin
			pick = old_way;
		end
		// A freshly filled way ages every valid way.
		if (found || evict) begin
			old_rank = {1'b0, rank_rd_q[pick]};
		end else begin
			old_rank = (WIDX + 1)'(WAYS);
		end
		new_tags       = tag_rd_q;
		new_tags[pick] = tag_q;
		for (int k = 0; k < WAYS; k++) begin
			if (WIDX'(k) == pick) begin
				new_ranks[k] = '0;
			end else if (row_valid[k] && ({1'b0, rank_rd_q[k]} < old_rank)) begin
				new_ranks[k] = rank_rd_q[k] + WIDX'(1);
			end else begin
				new_ranks[k] = rank_rd_q[k];
			end
		end
		pick_ext  = (WIDX + 2)'(pick);
		miss_next = (miss_q == '1) ? miss_q : miss_q + COUNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			tag_rd_q  <= tag_mem[req_set];
			rank_rd_q <= rank_mem[req_set];
			mode_q    <= req.mode;
			set_q     <= req_set;
			tag_q     <= req_tag;
		end
		if (cmd.commit && !mode_q) begin
			tag_mem[set_q]  <= new_tags;
			rank_mem[set_q] <= new_ranks;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (mode_q) begin
				rsp_q <= '0;
			end else begin
				rsp_q.hit        <= found;
				rsp_q.evicted    <= evict;
				rsp_q.way_used   <= pick_ext[WAY_OUT_W-1:0];
				rsp_q.miss_count <= found ? miss_q : miss_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			miss_q  <= '0;
		end else if (cmd.commit) begin
			if (mode_q) begin
				valid_q <= '0;
				miss_q  <= '0;
			end else begin
				valid_q[set_q][pick] <= 1'b1;
				if (!found) begin
					miss_q <= miss_next;
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

>>> hw/rtl/salcmc_checker.sv
// Port-level checker for the LRU cache tag block, bound to the top level.
module salcmc_checker import salcmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a lookup is in progress");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.evicted)
		else $error("hit reported together with an eviction");

	a_evict_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> rsp.miss_count != '0)
		else $error("eviction reported with a zero miss count");

endmodule

bind set_assoc_lru_cache_miss_counter salcmc_checker u_chk (.*);
